// File: rtl/core/cmsi_pkg.sv
`default_nettype none
package cmsi_pkg;

  localparam int MaxStops = 16;
  localparam int IdxW     = $clog2(MaxStops);
  localparam int CntW     = $clog2(MaxStops + 1);

  localparam int PosW     = 17;
  localparam int FracW    = 16;
  localparam int ChanW    = 8;
  localparam int NumChan  = 4;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgRangeMin   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRangeMax   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStopsInUse = 2'd2;

  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeLookup = 1'b1;

  localparam logic StatusOk       = 1'b0;
  localparam logic StatusNoBracket = 1'b1;

  localparam logic [PosW-1:0] PosHalf = 17'd32768;
  localparam logic [PosW-1:0] PosOne  = 17'd65536;

  typedef struct packed {
    logic [PosW-1:0]                 pos;
    logic [NumChan-1:0][ChanW-1:0]   ch;
  } stop_t;

endpackage
`default_nettype wire

// File: rtl/core/colormap_stop_interpolator_unit.sv
// load item: written to the stop table on accept, no result; the next item may follow at once
// lookup item: the input is stalled from accept until the result is emitted, so one item at a time
// the lookup runs on the shared restoring divider (one quotient bit per cycle,
// 16 quotient bits for scaling and 16 for the blend factor), one stop compared per cycle,
// and one channel blended per cycle through a single multiplier
// reset clears control and range registers to their defaults; the stop table is not cleared
`default_nettype none
module colormap_stop_interpolator_unit
  import cmsi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,

  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                mode_i,
  input  wire logic [15:0]         sample_i,
  input  wire logic [3:0]          stop_slot_i,
  input  wire logic [PosW-1:0]     stop_position_i,
  input  wire logic [ChanW-1:0]    stop_red_i,
  input  wire logic [ChanW-1:0]    stop_green_i,
  input  wire logic [ChanW-1:0]    stop_blue_i,
  input  wire logic [ChanW-1:0]    stop_alpha_i,

  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ChanW-1:0]         out_red_o,
  output logic [ChanW-1:0]         out_green_o,
  output logic [ChanW-1:0]         out_blue_o,
  output logic [ChanW-1:0]         out_alpha_o,
  output logic                     status_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSdiv = 3'd1;
  localparam logic [2:0] StPick = 3'd2;
  localparam logic [2:0] StScan = 3'd3;
  localparam logic [2:0] StFdiv = 3'd4;
  localparam logic [2:0] StMix  = 3'd5;
  localparam logic [2:0] StEmit = 3'd6;

  logic [2:0] state_q, state_d;

  logic [15:0]     range_min_q, range_max_q;
  logic [CntW-1:0] stops_q;

  stop_t tbl_q [MaxStops];

  logic [PosW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  stop_t            prev_q, prev_d;
  stop_t            cur_q, cur_d;
  logic [FracW-1:0] f_q, f_d;
  logic [1:0]       ch_q, ch_d;

  logic [FracW+1:0] rem_q, rem_d;
  logic [PosW-1:0]  den_q, den_d;
  logic [FracW-1:0] quo_q, quo_d;
  logic [3:0]       dcnt_q, dcnt_d;

  logic [NumChan-1:0][ChanW-1:0] res_ch_q, res_ch_d;
  logic                          res_st_q, res_st_d;

  logic                          out_valid_q, out_valid_d;
  logic [NumChan-1:0][ChanW-1:0] out_ch_q, out_ch_d;
  logic                          out_st_q, out_st_d;

  logic            in_acc;
  logic            tbl_we;
  logic [CntW-1:0] n_use;
  logic [IdxW-1:0] rd_idx;
  stop_t           rd_entry;

  logic [FracW+1:0] rem_sh;
  logic             div_ge;
  logic [FracW+1:0] rem_nx;
  logic [FracW-1:0] quo_nx;

  logic [ChanW-1:0]  mix_c0, mix_c1;
  logic signed [8:0] mix_dif;
  logic signed [25:0] mix_prod, mix_val, mix_rnd;
  logic [ChanW-1:0]  mix_out;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign tbl_we     = in_acc && (mode_i == ModeLoad) &&
                      ({1'b0, stop_slot_i} < 5'(MaxStops));

  assign n_use    = (stops_q > CntW'(MaxStops)) ? CntW'(MaxStops) : stops_q;
  assign rd_idx   = (state_q == StPick) ? IdxW'(n_use - 1'b1) : idx_q;
  assign rd_entry = tbl_q[rd_idx];

  // shared restoring divider step
  assign rem_sh = {rem_q[FracW:0], 1'b0};
  assign div_ge = (rem_sh >= {1'b0, den_q});
  assign rem_nx = div_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  assign quo_nx = {quo_q[FracW-2:0], div_ge};

  // one channel blend per cycle
  assign mix_c0   = prev_q.ch[ch_q];
  assign mix_c1   = cur_q.ch[ch_q];
  assign mix_dif  = $signed({1'b0, mix_c1}) - $signed({1'b0, mix_c0});
  assign mix_prod = $signed({{17{mix_dif[8]}}, mix_dif}) * $signed({10'b0, f_q});
  assign mix_val  = $signed({2'b0, mix_c0, 16'b0}) + mix_prod;
  assign mix_rnd  = mix_val + 26'sd32768;
  assign mix_out  = mix_val[25] ? '0 : mix_rnd[23:16];

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_q[IdxW'(stop_slot_i)] <= '{pos: stop_position_i,
                                     ch: {stop_alpha_i, stop_blue_i, stop_green_i, stop_red_i}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= 16'd0;
      range_max_q <= 16'd65535;
      stops_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgRangeMin:   range_min_q <= cfg_data_i;
        CfgRangeMax:   range_max_q <= cfg_data_i;
        CfgStopsInUse: stops_q     <= cfg_data_i[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    f_d         = f_q;
    ch_d        = ch_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quo_d       = quo_q;
    dcnt_d      = dcnt_q;
    res_ch_d    = res_ch_q;
    res_st_d    = res_st_q;
    out_ch_d    = out_ch_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc && (mode_i == ModeLookup)) begin
          state_d = StPick;
          if (range_max_q == range_min_q) begin
            pos_d = PosHalf;
          end else if (sample_i <= range_min_q) begin
            pos_d = '0;
          end else if (sample_i >= range_max_q) begin
            pos_d = PosOne;
          end else begin
            rem_d   = {2'b0, sample_i - range_min_q};
            den_d   = {1'b0, range_max_q - range_min_q};
            quo_d   = '0;
            dcnt_d  = '0;
            state_d = StSdiv;
          end
        end
      end
      StSdiv: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 4'd15) begin
          pos_d   = {1'b0, quo_nx};
          state_d = StPick;
        end
      end
      StPick: begin
        res_st_d = StatusOk;
        if (n_use == '0) begin
          res_ch_d = '0;
          state_d  = StEmit;
        end else if ((n_use == CntW'(1)) || pos_q[PosW-1]) begin
          res_ch_d = rd_entry.ch;
          state_d  = StEmit;
        end else begin
          idx_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        if (rd_entry.pos == pos_q) begin
          res_ch_d = rd_entry.ch;
          res_st_d = StatusOk;
          state_d  = StEmit;
        end else if (rd_entry.pos > pos_q) begin
          if (idx_q == '0) begin
            res_ch_d = '0;
            res_st_d = StatusNoBracket;
            state_d  = StEmit;
          end else begin
            cur_d   = rd_entry;
            rem_d   = {1'b0, pos_q - prev_q.pos};
            den_d   = rd_entry.pos - prev_q.pos;
            quo_d   = '0;
            dcnt_d  = '0;
            state_d = StFdiv;
          end
        end else begin
          prev_d = rd_entry;
          if (CntW'(idx_q) == (n_use - 1'b1)) begin
            res_ch_d = '0;
            res_st_d = StatusNoBracket;
            state_d  = StEmit;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      StFdiv: begin
        rem_d  = rem_nx;
        quo_d  = quo_nx;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == 4'd15) begin
          f_d     = quo_nx;
          ch_d    = '0;
          state_d = StMix;
        end
      end
      StMix: begin
        res_ch_d[ch_q] = mix_out;
        res_st_d       = StatusOk;
        ch_d           = ch_q + 1'b1;
        if (ch_q == 2'd3) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!out_valid_q || !out_stall_i) begin
          out_ch_d    = res_ch_q;
          out_st_d    = res_st_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    idx_q    <= idx_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    f_q      <= f_d;
    ch_q     <= ch_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    quo_q    <= quo_d;
    dcnt_q   <= dcnt_d;
    res_ch_q <= res_ch_d;
    res_st_q <= res_st_d;
    out_ch_q <= out_ch_d;
    out_st_q <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_ch_q[0];
  assign out_green_o = out_ch_q[1];
  assign out_blue_o  = out_ch_q[2];
  assign out_alpha_o = out_ch_q[3];
  assign status_o    = out_st_q;

endmodule
`default_nettype wire
